// ===== rtl/core/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest pair distance package
// Shared constants, payload structs, controller state type and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Sizing of the point store and of the compare lanes.
    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 16;
    localparam int DIST_BITS   = 34;
    localparam int LANES       = 16;
    localparam int GROUP_SIZE  = 4;
    localparam int GROUPS      = LANES / GROUP_SIZE;
    localparam int LANE_BITS   = $clog2(LANES);
    localparam int ADDR_BITS   = $clog2(MAX_POINTS);
    localparam int ROWS        = MAX_POINTS / LANES;
    localparam int ROW_BITS    = ADDR_BITS - LANE_BITS;
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int ROWCNT_BITS = ROW_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int SUM_BITS    = SQ_BITS + 1;
    localparam int WIDE_BITS   = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] min_dist_sq;
        logic [1:0]           status;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cpd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_empty;
        logic last;
        logic out_free;
    } cpd_stat_t;

    // Saturate a raw sum of squares to the distance width.
    function automatic logic [DIST_BITS-1:0] sat_dist(input logic [SUM_BITS-1:0] sum);
        logic [WIDE_BITS-1:0] wide;
        logic [DIST_BITS-1:0] res;
        wide = WIDE_BITS'(sum);
        if (wide > WIDE_BITS'(DIST_MAX))
            res = DIST_MAX;
        else
            res = wide[DIST_BITS-1:0];
        return res;
    endfunction

    // Smaller of two distances.
    function automatic logic [DIST_BITS-1:0] min_dist(input logic [DIST_BITS-1:0] a,
                                                      input logic [DIST_BITS-1:0] b);
        return (b < a) ? b : a;
    endfunction

endpackage

// ===== rtl/core/cpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Closest pair distance controller
// Sequences one point at a time: accept, scan the stored rows, drain the
// compare pipeline, then hand over the result on the last point of a set.
// ----------------------------------------------------------------------------
module cpd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  cpd_pkg::cpd_stat_t stat,
    output cpd_pkg::cpd_cmd_t  cmd
);

    cpd_pkg::state_t state_reg;
    cpd_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpd_pkg::ST_IDLE:
            begin
                if (point_valid)
                    state_next = cpd_pkg::ST_SCAN;
            end
            cpd_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                    state_next = cpd_pkg::ST_DRAIN;
            end
            cpd_pkg::ST_DRAIN:
            begin
                if (stat.pipe_empty)
                    state_next = cpd_pkg::ST_FINISH;
            end
            cpd_pkg::ST_FINISH:
            begin
                if (!stat.last || stat.out_free)
                    state_next = cpd_pkg::ST_IDLE;
            end
            default:
                state_next = cpd_pkg::ST_IDLE;
        endcase
    end

    // Outputs: commands to the datapath and the input stall.
    always_comb
    begin
        cmd         = '0;
        point_stall = 1'b1;
        unique case (state_reg)
            cpd_pkg::ST_IDLE:
            begin
                point_stall = 1'b0;
                cmd.load    = point_valid;
            end
            cpd_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            cpd_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            cpd_pkg::ST_FINISH:
            begin
                cmd.finish = stat.last && stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/cpd_datapath.sv =====
// ----------------------------------------------------------------------------
// Closest pair distance datapath
// Banked point store, sixteen-lane squared distance pipeline, minimum tree,
// set bookkeeping and the result output register.
// ----------------------------------------------------------------------------
module cpd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  cpd_pkg::point_t    point,
    input  cpd_pkg::cpd_cmd_t  cmd,
    output cpd_pkg::cpd_stat_t stat,
    output cpd_pkg::result_t   result,
    output logic               result_valid,
    input  logic               result_stall
);

    localparam int CB = cpd_pkg::COORD_BITS;
    localparam int DB = cpd_pkg::DIST_BITS;
    localparam int NL = cpd_pkg::LANES;
    localparam int NG = cpd_pkg::GROUPS;
    localparam int GS = cpd_pkg::GROUP_SIZE;

    // Point store: one bank per lane, point i in bank i mod LANES.
    logic [CB-1:0] x_mem [NL][cpd_pkg::ROWS];
    logic [CB-1:0] y_mem [NL][cpd_pkg::ROWS];

    // Set state and current point.
    logic [cpd_pkg::COUNT_BITS-1:0]  count_reg;
    logic                            overflow_reg;
    logic [DB-1:0]                   best_reg;
    logic [CB-1:0]                   cur_x_reg;
    logic [CB-1:0]                   cur_y_reg;
    logic                            last_reg;
    logic [cpd_pkg::COUNT_BITS-1:0]  limit_reg;
    logic [cpd_pkg::ROWCNT_BITS-1:0] rows_left_reg;
    logic [cpd_pkg::ROW_BITS-1:0]    row_reg;

    // Pipeline registers.
    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic          s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic [NL-1:0] s1_mask_reg, s2_mask_reg, s3_mask_reg;
    logic [CB-1:0] rd_x_reg [NL];
    logic [CB-1:0] rd_y_reg [NL];
    logic [CB-1:0] dx_reg [NL];
    logic [CB-1:0] dy_reg [NL];
    logic [cpd_pkg::SQ_BITS-1:0] sqx_reg [NL];
    logic [cpd_pkg::SQ_BITS-1:0] sqy_reg [NL];
    logic [DB-1:0] dist_reg [NL];
    logic [DB-1:0] grp_reg [NG];
    logic [DB-1:0] min_reg;

    // Output register.
    cpd_pkg::result_t result_reg;
    cpd_pkg::result_t result_next;
    logic             result_valid_reg;

    logic                            room;
    logic                            issue;
    logic [cpd_pkg::COUNT_BITS:0]    rows_sum;
    logic [cpd_pkg::ROWCNT_BITS-1:0] rows_total;
    logic [NL-1:0]                   mask_next;
    logic [CB-1:0]                   dx_next [NL];
    logic [CB-1:0]                   dy_next [NL];
    logic [DB-1:0]                   dist_next [NL];
    logic [DB-1:0]                   grp_next [NG];
    logic [DB-1:0]                   min_next;
    logic [1:0]                      status_next;

    assign room  = count_reg < cpd_pkg::COUNT_BITS'(cpd_pkg::MAX_POINTS);
    assign issue = cmd.scan && (rows_left_reg != '0);

    // Number of rows holding points stored before the current one.
    always_comb
    begin
        rows_sum   = {1'b0, count_reg} + (cpd_pkg::COUNT_BITS + 1)'(NL - 1);
        rows_total = rows_sum[cpd_pkg::LANE_BITS +: cpd_pkg::ROWCNT_BITS];
        if (!room)
            rows_total = '0;
    end

    // Store write on each accepted point that fits.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (cmd.load && room && count_reg[cpd_pkg::LANE_BITS-1:0] ==
                    cpd_pkg::LANE_BITS'(l))
            begin
                x_mem[l][count_reg[cpd_pkg::ADDR_BITS-1:cpd_pkg::LANE_BITS]] <=
                    point.x_coord;
                y_mem[l][count_reg[cpd_pkg::ADDR_BITS-1:cpd_pkg::LANE_BITS]] <=
                    point.y_coord;
            end
        end
    end

    // Store read: one row across all banks, data registered.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            rd_x_reg[l] <= x_mem[l][row_reg];
            rd_y_reg[l] <= y_mem[l][row_reg];
        end
    end

    // Lanes beyond the stored points of the set are masked out.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
            mask_next[l] = cpd_pkg::COUNT_BITS'({row_reg, cpd_pkg::LANE_BITS'(l)}) < limit_reg;
    end

    // Absolute coordinate differences.
    always_comb
    begin
        logic signed [CB:0] ddx;
        logic signed [CB:0] ddy;
        for (int l = 0; l < NL; l++)
        begin
            ddx = $signed({cur_x_reg[CB-1], cur_x_reg}) - $signed({rd_x_reg[l][CB-1], rd_x_reg[l]});
            ddy = $signed({cur_y_reg[CB-1], cur_y_reg}) - $signed({rd_y_reg[l][CB-1], rd_y_reg[l]});
            if (ddx < 0)
                ddx = -ddx;
            if (ddy < 0)
                ddy = -ddy;
            dx_next[l] = ddx[CB-1:0];
            dy_next[l] = ddy[CB-1:0];
        end
    end

    // Sum of squares, saturated, with masked lanes forced to the maximum.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (s3_mask_reg[l])
                dist_next[l] = cpd_pkg::sat_dist({1'b0, sqx_reg[l]} + {1'b0, sqy_reg[l]});
            else
                dist_next[l] = cpd_pkg::DIST_MAX;
        end
    end

    // Minimum tree: groups of four lanes, then across the groups.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = dist_reg[g*GS];
            for (int k = 1; k < GS; k++)
                grp_next[g] = cpd_pkg::min_dist(grp_next[g], dist_reg[g*GS + k]);
        end
        min_next = grp_reg[0];
        for (int g = 1; g < NG; g++)
            min_next = cpd_pkg::min_dist(min_next, grp_reg[g]);
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_mask_reg <= mask_next;
        s2_mask_reg <= s1_mask_reg;
        s3_mask_reg <= s2_mask_reg;
        for (int l = 0; l < NL; l++)
        begin
            dx_reg[l]   <= dx_next[l];
            dy_reg[l]   <= dy_next[l];
            sqx_reg[l]  <= dx_reg[l] * dx_reg[l];
            sqy_reg[l]  <= dy_reg[l] * dy_reg[l];
            dist_reg[l] <= dist_next[l];
        end
        for (int g = 0; g < NG; g++)
            grp_reg[g] <= grp_next[g];
        min_reg <= min_next;
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Current point, captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= point.x_coord;
            cur_y_reg <= point.y_coord;
        end
    end

    // Set bookkeeping and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            best_reg      <= cpd_pkg::DIST_MAX;
            last_reg      <= 1'b0;
            limit_reg     <= '0;
            rows_left_reg <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg      <= point.last_point;
                rows_left_reg <= rows_total;
                row_reg       <= '0;
                if (room)
                begin
                    limit_reg <= count_reg;
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    limit_reg    <= '0;
                    overflow_reg <= 1'b1;
                end
            end
            else if (issue)
            begin
                rows_left_reg <= rows_left_reg - 1'b1;
                row_reg       <= row_reg + 1'b1;
            end

            if (cmd.finish)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                best_reg     <= cpd_pkg::DIST_MAX;
            end
            else if (s6_valid_reg)
            begin
                best_reg <= cpd_pkg::min_dist(best_reg, min_reg);
            end
        end
    end

    // Result for the finished set.
    always_comb
    begin
        if (overflow_reg)
            status_next = cpd_pkg::STATUS_OVERFLOW;
        else if (count_reg < cpd_pkg::COUNT_BITS'(2))
            status_next = cpd_pkg::STATUS_TOO_FEW;
        else
            status_next = cpd_pkg::STATUS_OK;
        result_next.status = status_next;
        if (status_next == cpd_pkg::STATUS_TOO_FEW)
            result_next.min_dist_sq = cpd_pkg::DIST_MAX;
        else
            result_next.min_dist_sq = best_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.finish)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    // Status to the controller and output ports.
    assign stat.scan_done  = rows_left_reg <= cpd_pkg::ROWCNT_BITS'(1);
    assign stat.pipe_empty = !(s1_valid_reg || s2_valid_reg || s3_valid_reg ||
                               s4_valid_reg || s5_valid_reg || s6_valid_reg);
    assign stat.last       = last_reg;
    assign stat.out_free   = !result_valid_reg || !result_stall;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/core/closest_pair_distance.sv =====
// A point is compared with the earlier stored points of its set before the next point can
// be accepted: the scan reads one row of 16 banked points a cycle into the 6-stage pipeline,
// which is then drained; with nothing to scan no rows enter the pipeline.
// A set result is registered once the last point of the set has been scanned and drained;
// a result still stalled at the output holds the block and so its input.
// Reset (rst_n, asynchronous) empties the set and drops any result; the store is not cleared.
// ----------------------------------------------------------------------------
// Closest pair distance
// Finds the smallest squared distance between any two points of a planar
// set by exhaustive comparison against a banked point store.
// ----------------------------------------------------------------------------
module closest_pair_distance (
    input  logic             clk,
    input  logic             rst_n,
    input  cpd_pkg::point_t  point,
    input  logic             point_valid,
    output logic             point_stall,
    output cpd_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);

    cpd_pkg::cpd_cmd_t  cmd;
    cpd_pkg::cpd_stat_t stat;

    // Controller.
    cpd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Datapath.
    cpd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ===== tb/sv/closest_pair_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest pair distance checker
// Watches the point and result channels of the block. It keeps its own copy
// of the current point set and of the running minimum, works out the result
// of every set and compares each result transaction with the oldest one still
// awaited.
// ----------------------------------------------------------------------------
module closest_pair_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  cpd_pkg::point_t  point,
    input  logic             point_valid,
    input  logic             point_stall,
    input  cpd_pkg::result_t result,
    input  logic             result_valid,
    input  logic             result_stall,
    output int               mismatch_count,
    output int               sets_outstanding
);

    localparam int REPORT_LIMIT = 10;

    // Points of the set in progress, with its running minimum.
    logic signed [cpd_pkg::COORD_BITS-1:0] stored_x [cpd_pkg::MAX_POINTS];
    logic signed [cpd_pkg::COORD_BITS-1:0] stored_y [cpd_pkg::MAX_POINTS];
    int                                    stored_count;
    logic [cpd_pkg::DIST_BITS-1:0]         running_min;
    bit                                    store_overflowed;

    // Results of completed sets, oldest first.
    cpd_pkg::result_t                      awaited_results [$];

    // Squared distance between two points, saturated to the result width.
    function automatic logic [cpd_pkg::DIST_BITS-1:0] squared_gap(
        input logic signed [cpd_pkg::COORD_BITS-1:0] ax,
        input logic signed [cpd_pkg::COORD_BITS-1:0] ay,
        input logic signed [cpd_pkg::COORD_BITS-1:0] bx,
        input logic signed [cpd_pkg::COORD_BITS-1:0] by
    );
        longint dx;
        longint dy;
        longint total;
        dx    = longint'(ax) - longint'(bx);
        dy    = longint'(ay) - longint'(by);
        total = dx * dx + dy * dy;
        if (total > longint'(cpd_pkg::DIST_MAX))
            return cpd_pkg::DIST_MAX;
        return total[cpd_pkg::DIST_BITS-1:0];
    endfunction

    // Counts a failure and reports it while the report budget lasts.
    task automatic log_failure(input string text);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, text);
    endtask

    // Folds one accepted point into the set; the last point closes the set.
    task automatic add_point_to_set(input cpd_pkg::point_t p);
        logic [cpd_pkg::DIST_BITS-1:0] gap;
        cpd_pkg::result_t              set_result;
        if (stored_count < cpd_pkg::MAX_POINTS)
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                gap = squared_gap(p.x_coord, p.y_coord,
                                  stored_x[cpd_pkg::ADDR_BITS'(i)],
                                  stored_y[cpd_pkg::ADDR_BITS'(i)]);
                if (gap < running_min)
                    running_min = gap;
            end
            stored_x[cpd_pkg::ADDR_BITS'(stored_count)] = p.x_coord;
            stored_y[cpd_pkg::ADDR_BITS'(stored_count)] = p.y_coord;
            stored_count++;
        end
        else
        begin
            // The store is full: the point is dropped, but the set is marked.
            store_overflowed = 1'b1;
        end

        if (p.last_point)
        begin
            if (store_overflowed)
                set_result.status = cpd_pkg::STATUS_OVERFLOW;
            else if (stored_count < 2)
                set_result.status = cpd_pkg::STATUS_TOO_FEW;
            else
                set_result.status = cpd_pkg::STATUS_OK;
            if (set_result.status == cpd_pkg::STATUS_TOO_FEW)
                set_result.min_dist_sq = cpd_pkg::DIST_MAX;
            else
                set_result.min_dist_sq = running_min;
            awaited_results.push_back(set_result);
            stored_count     = 0;
            running_min      = cpd_pkg::DIST_MAX;
            store_overflowed = 1'b0;
        end
    endtask

    // Compares one result transaction with the oldest awaited result.
    task automatic check_result(input cpd_pkg::result_t got);
        cpd_pkg::result_t want;
        if (awaited_results.size() == 0)
        begin
            log_failure($sformatf("result with no set awaiting it: min_dist_sq %0d status %0d",
                                  got.min_dist_sq, got.status));
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.min_dist_sq !== want.min_dist_sq)
                log_failure($sformatf("min_dist_sq expected %0d, got %0d",
                                      want.min_dist_sq, got.min_dist_sq));
            if (got.status !== want.status)
                log_failure($sformatf("status expected %0d, got %0d",
                                      want.status, got.status));
        end
    endtask

    // Both channels are sampled at the clock edge; a result never belongs to a
    // point accepted at the same edge, so results are handled first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_count   = 0;
            stored_count     = 0;
            running_min      = cpd_pkg::DIST_MAX;
            store_overflowed = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (point_valid && !point_stall)
                add_point_to_set(point);
        end
        sets_outstanding = awaited_results.size();
    end

endmodule

// ===== tb/sv/tb_closest_pair_distance.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest pair distance testbench
// Feeds point sets to the block: a few hand-picked sets covering extreme
// coordinates, coincident points, single-point sets, an exactly full store and
// an overflowing store, then several hundred points in random sets. The sender
// works in bursts and the receiver stalls on its own pattern, including one
// long hold-off. A checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_closest_pair_distance;

    localparam int     POINT_TARGET = 600;
    localparam int     HOLD_CYCLES  = 4000;
    localparam int     DRAIN_CYCLES = 100;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    typedef enum int {
        SPREAD_SET,
        CLUSTER_SET,
        CORNER_SET
    } set_style_t;

    typedef enum int {
        OPEN_FLOW,
        SPARSE_STALLS,
        DENSE_STALLS
    } stall_mode_t;

    logic             clk;
    logic             rst_n;
    cpd_pkg::point_t  point;
    logic             point_valid;
    logic             point_stall;
    cpd_pkg::result_t result;
    logic             result_valid;
    logic             result_stall;
    int               mismatch_count;
    int               sets_outstanding;

    bit               hold_request;
    int               burst_left;
    int               points_sent;

    closest_pair_distance dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    closest_pair_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .point            (point),
        .point_valid      (point_valid),
        .point_stall      (point_stall),
        .result           (result),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .mismatch_count   (mismatch_count),
        .sets_outstanding (sets_outstanding)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Coordinates at and next to the ends of the range, and around zero.
    function automatic logic signed [cpd_pkg::COORD_BITS-1:0] corner_coord();
        case ($urandom_range(0, 6))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // Offers one point and returns at the edge where it is taken. Between
    // bursts the valid line drops for a random number of cycles.
    task automatic send_point(input logic signed [cpd_pkg::COORD_BITS-1:0] x,
                              input logic signed [cpd_pkg::COORD_BITS-1:0] y,
                              input logic                                  last);
        int              gap;
        cpd_pkg::point_t p;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                point_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        p.x_coord   = x;
        p.y_coord   = y;
        p.last_point = last;
        point       <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (point_stall);
        points_sent++;
    endtask

    // A set of spread points as large as requested. Points beyond the store
    // repeat the first two stored points, so comparing them by mistake
    // would show up as a zero distance.
    task automatic send_wide_set(input int count);
        logic signed [cpd_pkg::COORD_BITS-1:0] first_x [2];
        logic signed [cpd_pkg::COORD_BITS-1:0] first_y [2];
        logic signed [cpd_pkg::COORD_BITS-1:0] x;
        logic signed [cpd_pkg::COORD_BITS-1:0] y;
        for (int i = 0; i < count; i++)
        begin
            if (i < cpd_pkg::MAX_POINTS)
            begin
                x = cpd_pkg::COORD_BITS'($urandom);
                y = cpd_pkg::COORD_BITS'($urandom);
                if (i < 2)
                begin
                    first_x[i[0]] = x;
                    first_y[i[0]] = y;
                end
            end
            else
            begin
                x = first_x[i[0]];
                y = first_y[i[0]];
            end
            send_point(x, y, i == count - 1);
        end
    endtask

    // A short set whose points are spread, clustered or on the range corners.
    task automatic send_random_set(input int count);
        set_style_t                            style;
        logic signed [cpd_pkg::COORD_BITS-1:0] base_x;
        logic signed [cpd_pkg::COORD_BITS-1:0] base_y;
        logic signed [cpd_pkg::COORD_BITS-1:0] x;
        logic signed [cpd_pkg::COORD_BITS-1:0] y;
        style  = set_style_t'($urandom_range(0, 2));
        base_x = cpd_pkg::COORD_BITS'($urandom);
        base_y = cpd_pkg::COORD_BITS'($urandom);
        for (int i = 0; i < count; i++)
        begin
            case (style)
                SPREAD_SET:
                begin
                    x = cpd_pkg::COORD_BITS'($urandom);
                    y = cpd_pkg::COORD_BITS'($urandom);
                end
                CLUSTER_SET:
                begin
                    x = base_x + cpd_pkg::COORD_BITS'($urandom_range(0, 7));
                    y = base_y + cpd_pkg::COORD_BITS'($urandom_range(0, 7));
                end
                default:
                begin
                    x = corner_coord();
                    y = corner_coord();
                end
            endcase
            send_point(x, y, i == count - 1);
        end
    endtask

    // Receiver: stalls on its own changing pattern, with one long hold-off
    // when the stimulus asks for it.
    initial
    begin
        int          hold_left;
        int          stretch_left;
        int          beat;
        stall_mode_t mode;
        logic        stall_now;
        bit          hold_taken;
        hold_left    = 0;
        stretch_left = 0;
        beat         = 0;
        mode         = OPEN_FLOW;
        hold_taken   = 1'b0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (stretch_left == 0)
            begin
                mode         = stall_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(20, 150);
            end
            stretch_left--;
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else
            begin
                case (mode)
                    OPEN_FLOW:     stall_now = 1'b0;
                    SPARSE_STALLS: stall_now = ($urandom_range(0, 2) == 0);
                    default:       stall_now = (beat % 4 != 0);
                endcase
            end
            result_stall <= stall_now;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int random_start;
        int pick;
        int set_size;
        rst_n        <= 1'b0;
        point        <= '0;
        point_valid  <= 1'b0;
        hold_request  = 1'b0;
        burst_left    = 0;
        points_sent   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone point: too few points for a distance.
        send_point(16'sd0, 16'sd0, 1'b1);
        // Opposite corners give the widest distance.
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        // Coincident points give zero.
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
        // Alternating bit patterns and unit steps around the origin.
        send_point(16'sh5555, 16'shAAAA, 1'b0);
        send_point(16'shAAAA, 16'sh5555, 1'b0);
        send_point(-16'sd1, -16'sd1, 1'b0);
        send_point(16'sd1, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd1, 1'b1);
        // Minimum found late in the set.
        send_point(16'sd100, 16'sd200, 1'b0);
        send_point(-16'sd100, -16'sd200, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd103, 16'sd204, 1'b1);
        // Store filled exactly, then overflowed by two points.
        send_wide_set(cpd_pkg::MAX_POINTS);
        send_wide_set(cpd_pkg::MAX_POINTS + 2);

        // The set after an overflow starts clean. Its result is held off for a
        // long stretch, so the next set's result backs the block up into its
        // input while points keep coming.
        hold_request = 1'b1;
        send_point(16'sd5, -16'sd5, 1'b1);

        // Random sets.
        random_start = points_sent;
        while (points_sent - random_start < POINT_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                set_size = 1;
            else if (pick < 80)
                set_size = $urandom_range(2, 12);
            else if (pick < 95)
                set_size = $urandom_range(13, 40);
            else
                set_size = $urandom_range(41, 120);
            send_random_set(set_size);
        end
        point_valid <= 1'b0;

        // Wait for the outstanding results, then give the block time to show
        // anything unexpected.
        @(posedge clk);
        while (sets_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cpd_pkg.sv
rtl/core/cpd_ctrl.sv
rtl/core/cpd_datapath.sv
rtl/core/closest_pair_distance.sv
tb/sv/closest_pair_checker.sv
tb/sv/tb_closest_pair_distance.sv
